// ===== src/buzzer_tone_pattern_sequencer_core_assert.svh =====
// Assertion macros for the buzzer tone sequencer, empty when built for synthesis.
`ifndef BUZZER_TONE_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define BUZZER_TONE_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BTS_ASSERT(name, clk, rst, prop, msg)
`define BTS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/bts_pkg.sv =====
// Shared types, constants and tables of the buzzer tone sequencer.
`default_nettype none
package bts_pkg;
  localparam int CMD_W      = 3;
  localparam int LEVEL_W    = 8;
  localparam int FREQ_W     = 12;
  localparam int MODE_W     = 4;
  localparam int LVL_W      = 3;
  localparam int POS_W      = 8;
  localparam int CP_W       = 10;
  localparam int PE_W       = 10;
  localparam int STEP_W     = 5;
  localparam int INC_W      = 13;
  localparam int IV_W       = 6;
  localparam int SLEN_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int SWEEP_STEPS_DEF = 20;
  localparam int MAX_LEVEL_DEF   = 6;
  localparam int CYCLE_MS        = 1000;
  localparam int TO0_STEPS       = 30;
  localparam int SLEEP_SWEEP_MS  = 500;
  localparam int IV_MAX          = 63;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUTTON  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LEVEL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SLEEP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_IND = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BEEP   = 3'd5;

  localparam logic [FREQ_W-1:0] F_LOW_BLIP   = 12'd1200;
  localparam logic [FREQ_W-1:0] F_HIGH_BLIP  = 12'd3000;
  localparam logic [FREQ_W-1:0] F_TO0_START  = 12'd3500;
  localparam logic [FREQ_W-1:0] F_SLEEP_HIGH = 12'd2800;
  localparam logic [FREQ_W-1:0] F_SLEEP_LOW  = 12'd800;
  localparam logic [FREQ_W-1:0] F_SLEEP_END  = 12'd300;
  localparam logic [FREQ_W-1:0] F_WAKE_MID   = 12'd2000;
  localparam logic [FREQ_W-1:0] F_WAKE_HIGH  = 12'd3500;

  localparam logic [MODE_W-1:0] PM_IDLE  = 4'd0;
  localparam logic [MODE_W-1:0] PM_BEEP  = 4'd1;
  localparam logic [MODE_W-1:0] PM_UP    = 4'd2;
  localparam logic [MODE_W-1:0] PM_DOWN  = 4'd3;
  localparam logic [MODE_W-1:0] PM_TO1   = 4'd4;
  localparam logic [MODE_W-1:0] PM_TO0   = 4'd5;
  localparam logic [MODE_W-1:0] PM_SLEEP = 4'd6;
  localparam logic [MODE_W-1:0] PM_WAKE  = 4'd7;
  localparam logic [MODE_W-1:0] PM_END   = 4'd8;

  typedef enum logic [8:0] {
    MODE_IDLE  = 9'b000000001,
    MODE_BEEP  = 9'b000000010,
    MODE_UP    = 9'b000000100,
    MODE_DOWN  = 9'b000001000,
    MODE_TO1   = 9'b000010000,
    MODE_TO0   = 9'b000100000,
    MODE_SLEEP = 9'b001000000,
    MODE_WAKE  = 9'b010000000,
    MODE_END   = 9'b100000000
  } mode_t;

  typedef struct packed {
    logic [FREQ_W-1:0] beep_frequency;
    logic [7:0]        beep_length_ms;
    logic [SLEN_W-1:0] sweep_length_ms;
    logic [7:0]        end_hold_ms;
    logic [POS_W-1:0]  slot_length_ms;
    logic [7:0]        slot_beep_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    beep_frequency:  12'd3200,
    beep_length_ms:  8'd20,
    sweep_length_ms: 10'd150,
    end_hold_ms:     8'd50,
    slot_length_ms:  8'd166,
    slot_beep_ms:    8'd120
  };

  typedef struct packed {
    logic [LVL_W-1:0] slot;
    logic [POS_W-1:0] pos;
  } slot_view_t;

  typedef struct packed {
    logic              tone_on;
    logic [FREQ_W-1:0] tone_freq;
    logic [MODE_W-1:0] player_mode;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] code;
    case (m)
      MODE_IDLE:  code = PM_IDLE;
      MODE_BEEP:  code = PM_BEEP;
      MODE_UP:    code = PM_UP;
      MODE_DOWN:  code = PM_DOWN;
      MODE_TO1:   code = PM_TO1;
      MODE_TO0:   code = PM_TO0;
      MODE_SLEEP: code = PM_SLEEP;
      MODE_WAKE:  code = PM_WAKE;
      MODE_END:   code = PM_END;
      default:    code = PM_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [FREQ_W-1:0] level_tone(logic [LVL_W-1:0] lvl);
    logic [FREQ_W-1:0] f;
    case (lvl)
      3'd0:    f = 12'd2000;
      3'd1:    f = 12'd2400;
      3'd2:    f = 12'd2700;
      3'd3:    f = 12'd3000;
      3'd4:    f = 12'd3200;
      3'd5:    f = 12'd3400;
      3'd6:    f = 12'd3600;
      default: f = 12'd3600;
    endcase
    return f;
  endfunction
endpackage
`default_nettype wire

// ===== src/bts_in_if.sv =====
// Input channel of the buzzer tone sequencer: commands and millisecond ticks.
`default_nettype none
interface bts_in_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [LEVEL_W-1:0] level_from;
  logic [LEVEL_W-1:0] level_to;
  modport source(output valid, output cmd, output level_from, output level_to, input ready);
  modport sink(input valid, input cmd, input level_from, input level_to, output ready);
endinterface
`default_nettype wire

// ===== src/bts_out_if.sv =====
// Result channel of the buzzer tone sequencer: buzzer drive after each item.
`default_nettype none
interface bts_out_if;
  import bts_pkg::*;
  logic              valid;
  logic              ready;
  logic              tone_on;
  logic [FREQ_W-1:0] tone_freq;
  logic [MODE_W-1:0] player_mode;
  modport source(output valid, output tone_on, output tone_freq, output player_mode,
                 input ready);
  modport sink(input valid, input tone_on, input tone_freq, input player_mode,
               output ready);
endinterface
`default_nettype wire

// ===== src/buzzer_tone_pattern_sequencer_core.sv =====
// Top level of the buzzer tone sequencer: input stage, config registers and result stage.
// The item channel takes one millisecond tick or one command per transfer; every item
// gives exactly one result transfer with the buzzer drive (tone on, frequency in hertz)
// and the player mode that hold once the item has taken effect.
// An accepted item is held in the input stage; when it advances, the player state is
// updated from it and the result is registered at the same edge. One item is taken per
// cycle when results drain and no slot division runs.
// When the result receiver stalls, the result register holds its value and the input
// stage keeps at most one further item; the item channel's ready drops until the
// result is taken.
// Configuration registers are written through cfg_we, cfg_index and cfg_data at any
// edge with cfg_we high; the user must write them only while no item is in flight, as
// the block does not enforce it. A write to the slot length starts a serial division
// that rebuilds the indicator slot and offset from the cycle position; ready is low
// while it runs. Synchronous reset sets player idle, tone off, indicator level zero, no
// item or result held; the item and result data registers are not reset.
`default_nettype none
`include "buzzer_tone_pattern_sequencer_core_assert.svh"
module buzzer_tone_pattern_sequencer_core #(
  parameter int SWEEP_STEPS = bts_pkg::SWEEP_STEPS_DEF,
  parameter int MAX_LEVEL   = bts_pkg::MAX_LEVEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bts_in_if.sink                         item,
  bts_out_if.source                      result,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bts_pkg::*;

  cfg_t               cfg;
  logic               stage_valid;
  logic [CMD_W-1:0]   stage_cmd;
  logic [LEVEL_W-1:0] stage_from;
  logic [LEVEL_W-1:0] stage_to;
  logic               out_valid;
  result_t            out_data;
  result_t            res_next;
  slot_view_t         slot_view;
  logic               slot_busy;
  logic               advance;
  logic               accept;

  assign advance = stage_valid && (!out_valid || result.ready) && !slot_busy;
  assign item.ready = !slot_busy && (!stage_valid || advance);
  assign accept = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEEP_FREQ:   cfg.beep_frequency <= cfg_data[FREQ_W-1:0];
        CFG_BEEP_LENGTH: cfg.beep_length_ms <= cfg_data[7:0];
        CFG_SWEEP_LEN:   cfg.sweep_length_ms <= cfg_data[SLEN_W-1:0];
        CFG_END_HOLD:    cfg.end_hold_ms <= cfg_data[7:0];
        CFG_SLOT_LENGTH: cfg.slot_length_ms <= cfg_data[POS_W-1:0];
        CFG_SLOT_BEEP:   cfg.slot_beep_ms <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= item.cmd;
      stage_from <= item.level_from;
      stage_to <= item.level_to;
    end
  end

  bts_slot_track #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_slot_track (
    .clk(clk),
    .rst(rst),
    .tick(advance && stage_cmd == CMD_TICK),
    .recalc(cfg_we && cfg_index == CFG_SLOT_LENGTH),
    .slot_length(cfg.slot_length_ms),
    .view(slot_view),
    .busy(slot_busy)
  );

  bts_player #(
    .SWEEP_STEPS(SWEEP_STEPS),
    .MAX_LEVEL(MAX_LEVEL)
  ) u_player (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .cmd(stage_cmd),
    .level_from(stage_from),
    .level_to(stage_to),
    .cfg(cfg),
    .view(slot_view),
    .res(res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.tone_on = out_data.tone_on;
  assign result.tone_freq = out_data.tone_freq;
  assign result.player_mode = out_data.player_mode;

  `BTS_ASSERT_IMPLY(a_off_means_zero_freq, clk, rst, result.valid && !result.tone_on, result.tone_freq == '0, "Tone frequency is not zero while the tone is off.")
  `BTS_ASSERT_IMPLY(a_busy_blocks_items, clk, rst, slot_busy, !item.ready, "Items are taken while the slot division runs.")
  `BTS_ASSERT(a_slot_write_starts_div, clk, rst, cfg_we && cfg_index == CFG_SLOT_LENGTH |=> slot_busy, "Slot length write did not start the division.")
  `BTS_ASSERT(a_advance_gives_result, clk, rst, advance |=> result.valid, "A processed item left no result.")
endmodule
`default_nettype wire

// ===== src/bts_slot_track.sv =====
// Indicator cycle position with slot index and offset, and a serial divider to rebuild them.
`default_nettype none
module bts_slot_track #(
  parameter int MAX_LEVEL = bts_pkg::MAX_LEVEL_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick,
  input  logic                      recalc,
  input  logic [bts_pkg::POS_W-1:0] slot_length,
  output bts_pkg::slot_view_t       view,
  output logic                      busy
);
  import bts_pkg::*;

  localparam int DIV_STEPS = CP_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [LVL_W-1:0] SLOT_LAST = LVL_W'(MAX_LEVEL - 1);

  logic [CP_W-1:0]  cycle_position;
  logic [CP_W-1:0]  cp_inc;
  logic [LVL_W-1:0] slot;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] len_eff;
  logic [POS_W:0]   pos_inc;
  logic [CNT_W-1:0] div_count;
  logic [CP_W-1:0]  div_quo;
  logic [POS_W-1:0] div_rem;
  logic [POS_W:0]   trial;
  logic             trial_fit;
  logic [CP_W-1:0]  quo_step;
  logic [POS_W-1:0] rem_step;
  logic [LVL_W-1:0] quo_slot;

  assign len_eff = (slot_length == '0) ? POS_W'(1) : slot_length;
  assign cp_inc = (cycle_position == CP_W'(CYCLE_MS - 1)) ? '0 : cycle_position + 1'b1;
  assign pos_inc = {1'b0, pos} + 1'b1;

  // Slot and offset as they stand after the current tick.
  always_comb begin
    view.slot = slot;
    view.pos = pos_inc[POS_W-1:0];
    if (cp_inc == '0) begin
      view = '0;
    end else if (pos_inc == {1'b0, len_eff}) begin
      view.pos = '0;
      view.slot = (slot == SLOT_LAST) ? slot : slot + 1'b1;
    end
  end

  // One restoring division step per cycle while busy.
  assign trial = {div_rem, div_quo[CP_W-1]};
  assign trial_fit = (trial >= {1'b0, len_eff});
  assign rem_step = trial_fit ? POS_W'(trial - {1'b0, len_eff}) : trial[POS_W-1:0];
  assign quo_step = {div_quo[CP_W-2:0], trial_fit};
  assign quo_slot = (quo_step > CP_W'(SLOT_LAST)) ? SLOT_LAST : quo_step[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_position <= '0;
      slot <= '0;
      pos <= '0;
      busy <= 1'b0;
      div_count <= '0;
    end else if (recalc) begin
      busy <= 1'b1;
      div_count <= '0;
      div_quo <= cycle_position;
      div_rem <= '0;
    end else if (busy) begin
      div_quo <= quo_step;
      div_rem <= rem_step;
      div_count <= div_count + 1'b1;
      if (div_count == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        slot <= quo_slot;
        pos <= rem_step;
      end
    end else if (tick) begin
      cycle_position <= cp_inc;
      slot <= view.slot;
      pos <= view.pos;
    end
  end
endmodule
`default_nettype wire

// ===== src/bts_player.sv =====
// Pattern player and background indicator state with their combinational next-state update.
`default_nettype none
module bts_player #(
  parameter int SWEEP_STEPS = bts_pkg::SWEEP_STEPS_DEF,
  parameter int MAX_LEVEL   = bts_pkg::MAX_LEVEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [bts_pkg::CMD_W-1:0]   cmd,
  input  logic [bts_pkg::LEVEL_W-1:0] level_from,
  input  logic [bts_pkg::LEVEL_W-1:0] level_to,
  input  bts_pkg::cfg_t               cfg,
  input  bts_pkg::slot_view_t         view,
  output bts_pkg::result_t            res
);
  import bts_pkg::*;

  // Exact division by the step count as a multiply by a rounded-up reciprocal.
  localparam int STEP_L = $clog2(SWEEP_STEPS);
  localparam int DIFF_SH = FREQ_W + STEP_L;
  localparam int DIFF_MW = FREQ_W + 2;
  localparam int DIFF_PW = FREQ_W + DIFF_MW;
  localparam logic [DIFF_MW-1:0] DIFF_MUL =
    DIFF_MW'(((64'd1 << DIFF_SH) + SWEEP_STEPS - 1) / SWEEP_STEPS);
  localparam int LEN_SH = SLEN_W + STEP_L;
  localparam int LEN_MW = SLEN_W + 2;
  localparam int LEN_PW = SLEN_W + LEN_MW;
  localparam logic [LEN_MW-1:0] LEN_MUL =
    LEN_MW'(((64'd1 << LEN_SH) + SWEEP_STEPS - 1) / SWEEP_STEPS);

  localparam int SLEEP_DIFF = 2500;
  localparam int SLEEP_INC_RAW = SLEEP_DIFF / SWEEP_STEPS;
  localparam int SLEEP_IV_RAW = SLEEP_SWEEP_MS / SWEEP_STEPS;
  localparam logic [INC_W-1:0] SLEEP_INC =
    INC_W'((SLEEP_INC_RAW < 1) ? 1 : SLEEP_INC_RAW);
  localparam logic [IV_W-1:0] SLEEP_IV =
    IV_W'((SLEEP_IV_RAW > IV_MAX) ? IV_MAX : SLEEP_IV_RAW);
  localparam int SUM_W = FREQ_W + 3;
  localparam logic [PE_W-1:0] PE_MAX = '1;

  mode_t             mode, mode_next;
  logic [STEP_W-1:0] pattern_step, pattern_step_next;
  logic [PE_W-1:0]   phase_elapsed, phase_elapsed_next;
  logic [FREQ_W-1:0] sweep_current, sweep_current_next;
  logic [FREQ_W-1:0] sweep_target, sweep_target_next;
  logic [INC_W-1:0]  sweep_increment, sweep_increment_next;
  logic [IV_W-1:0]   sweep_interval, sweep_interval_next;
  logic [LVL_W-1:0]  indicator_level, indicator_level_next;
  logic              indicator_beeping, indicator_beeping_next;
  logic              tone_active, tone_active_next;
  logic [FREQ_W-1:0] tone_value, tone_value_next;

  logic [LVL_W-1:0]      from_sat, to_sat;
  logic [FREQ_W-1:0]     tone_from, tone_to, diff;
  logic                  sweep_up;
  logic [DIFF_PW-1:0]    diff_prod;
  logic [LEN_PW-1:0]     len_prod;
  logic [INC_W-1:0]      inc_quot, lc_inc;
  logic [SLEN_W-1:0]     iv_quot;
  logic [IV_W-1:0]       lc_iv;
  logic [2*STEP_W-1:0]   step_sq;
  logic [FREQ_W-1:0]     to0_tone;
  logic signed [SUM_W-1:0] sweep_sum, target_s;
  logic                  sweep_done;
  logic                  want;

  assign from_sat = (level_from > LEVEL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level_from[LVL_W-1:0];
  assign to_sat = (level_to > LEVEL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level_to[LVL_W-1:0];
  assign tone_from = level_tone(from_sat);
  assign tone_to = level_tone(to_sat);
  assign sweep_up = (to_sat > from_sat);
  assign diff = sweep_up ? tone_to - tone_from : tone_from - tone_to;
  assign diff_prod = DIFF_PW'(diff) * DIFF_PW'(DIFF_MUL);
  assign inc_quot = INC_W'(diff_prod >> DIFF_SH);
  assign lc_inc = (inc_quot == '0) ? INC_W'(1) : inc_quot;
  assign len_prod = LEN_PW'(cfg.sweep_length_ms) * LEN_PW'(LEN_MUL);
  assign iv_quot = SLEN_W'(len_prod >> LEN_SH);
  assign lc_iv = (iv_quot > SLEN_W'(IV_MAX)) ? IV_W'(IV_MAX) : iv_quot[IV_W-1:0];

  assign step_sq = {{STEP_W{1'b0}}, pattern_step} * {{STEP_W{1'b0}}, pattern_step};
  assign to0_tone = F_TO0_START - FREQ_W'({2'b00, step_sq} * 12'd3);

  assign target_s = $signed(SUM_W'(sweep_target));
  assign sweep_sum = (mode == MODE_UP)
                   ? $signed(SUM_W'(sweep_current)) + $signed(SUM_W'(sweep_increment))
                   : $signed(SUM_W'(sweep_current)) - $signed(SUM_W'(sweep_increment));
  assign sweep_done = (mode == MODE_UP) ? (sweep_sum >= target_s) : (sweep_sum <= target_s);

  assign want = (view.slot < indicator_level) && (view.pos < cfg.slot_beep_ms);

  always_comb begin
    mode_next = mode;
    pattern_step_next = pattern_step;
    phase_elapsed_next = phase_elapsed;
    sweep_current_next = sweep_current;
    sweep_target_next = sweep_target;
    sweep_increment_next = sweep_increment;
    sweep_interval_next = sweep_interval;
    indicator_level_next = indicator_level;
    indicator_beeping_next = indicator_beeping;
    tone_active_next = tone_active;
    tone_value_next = tone_value;
    if (advance) begin
      case (cmd)
        CMD_TICK: begin
          if (phase_elapsed != PE_MAX) begin
            phase_elapsed_next = phase_elapsed + 1'b1;
          end
          if (indicator_level != '0) begin
            if (mode == MODE_IDLE) begin
              if (want != indicator_beeping) begin
                tone_active_next = want;
                if (want) begin
                  tone_value_next = level_tone(indicator_level);
                end
                indicator_beeping_next = want;
              end
            end else begin
              indicator_beeping_next = 1'b0;
            end
          end
          case (mode)
            MODE_BEEP: begin
              if (phase_elapsed_next >= PE_W'(cfg.beep_length_ms)) begin
                tone_active_next = 1'b0;
                mode_next = MODE_IDLE;
              end
            end
            MODE_UP, MODE_DOWN: begin
              if (phase_elapsed_next >= PE_W'(sweep_interval)) begin
                phase_elapsed_next = '0;
                tone_active_next = 1'b1;
                if (sweep_done) begin
                  tone_value_next = sweep_target;
                  mode_next = MODE_END;
                end else begin
                  sweep_current_next = FREQ_W'(sweep_sum);
                  tone_value_next = FREQ_W'(sweep_sum);
                end
              end
            end
            MODE_TO1: begin
              if (pattern_step < STEP_W'(3)) begin
                if (phase_elapsed_next >= PE_W'(50)) begin
                  tone_active_next = 1'b1;
                  tone_value_next = (pattern_step == STEP_W'(1)) ? F_HIGH_BLIP : F_LOW_BLIP;
                  pattern_step_next = pattern_step + 1'b1;
                  phase_elapsed_next = '0;
                end
              end else if (phase_elapsed_next >= PE_W'(80)) begin
                mode_next = MODE_END;
                phase_elapsed_next = '0;
              end
            end
            MODE_TO0: begin
              if (phase_elapsed_next >= PE_W'(10)) begin
                phase_elapsed_next = '0;
                if (pattern_step < STEP_W'(TO0_STEPS)) begin
                  tone_active_next = 1'b1;
                  tone_value_next = to0_tone;
                  pattern_step_next = pattern_step + 1'b1;
                end else begin
                  mode_next = MODE_END;
                end
              end
            end
            MODE_SLEEP: begin
              if (pattern_step < STEP_W'(7)) begin
                if (phase_elapsed_next >= PE_W'(60)) begin
                  tone_active_next = 1'b1;
                  tone_value_next = pattern_step[0] ? F_SLEEP_HIGH : F_SLEEP_LOW;
                  pattern_step_next = pattern_step + 1'b1;
                  phase_elapsed_next = '0;
                end
              end else if (phase_elapsed_next >= PE_W'(60)) begin
                sweep_current_next = F_SLEEP_HIGH;
                sweep_target_next = F_SLEEP_END;
                sweep_increment_next = SLEEP_INC;
                sweep_interval_next = SLEEP_IV;
                mode_next = MODE_DOWN;
                phase_elapsed_next = '0;
                tone_active_next = 1'b1;
                tone_value_next = F_SLEEP_HIGH;
              end
            end
            MODE_WAKE: begin
              if (pattern_step < STEP_W'(4)) begin
                // Even steps hold a tone for 70 ms, odd steps are 25 ms gaps.
                if (phase_elapsed_next >= (pattern_step[0] ? PE_W'(25) : PE_W'(70))) begin
                  tone_active_next = pattern_step[0];
                  if (pattern_step[0]) begin
                    tone_value_next = (pattern_step == STEP_W'(1)) ? F_WAKE_MID : F_WAKE_HIGH;
                  end
                  pattern_step_next = pattern_step + 1'b1;
                  phase_elapsed_next = '0;
                end
              end else if (phase_elapsed_next >= PE_W'(130)) begin
                mode_next = MODE_END;
                phase_elapsed_next = '0;
              end
            end
            MODE_END: begin
              if (phase_elapsed_next >= PE_W'(cfg.end_hold_ms)) begin
                tone_active_next = 1'b0;
                mode_next = MODE_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_BUTTON: begin
          if (mode == MODE_IDLE || mode == MODE_BEEP) begin
            mode_next = MODE_BEEP;
            phase_elapsed_next = '0;
            tone_active_next = 1'b1;
            tone_value_next = cfg.beep_frequency;
          end
        end
        CMD_LEVEL: begin
          if (from_sat != to_sat) begin
            tone_active_next = 1'b1;
            phase_elapsed_next = '0;
            if (to_sat == LVL_W'(1)) begin
              mode_next = MODE_TO1;
              pattern_step_next = '0;
              tone_value_next = F_HIGH_BLIP;
            end else if (to_sat == '0 && from_sat == LVL_W'(1)) begin
              mode_next = MODE_TO0;
              pattern_step_next = '0;
              tone_value_next = F_TO0_START;
            end else begin
              sweep_current_next = tone_from;
              sweep_target_next = tone_to;
              sweep_increment_next = lc_inc;
              sweep_interval_next = lc_iv;
              mode_next = sweep_up ? MODE_UP : MODE_DOWN;
              tone_value_next = tone_from;
            end
          end
        end
        CMD_SLEEP: begin
          mode_next = MODE_SLEEP;
          pattern_step_next = '0;
          phase_elapsed_next = '0;
          tone_active_next = 1'b1;
          tone_value_next = F_SLEEP_HIGH;
        end
        CMD_WAKE: begin
          mode_next = MODE_WAKE;
          pattern_step_next = '0;
          phase_elapsed_next = '0;
          tone_active_next = 1'b1;
          tone_value_next = F_LOW_BLIP;
        end
        CMD_SET_IND: begin
          indicator_level_next = to_sat;
          if (to_sat == '0) begin
            indicator_beeping_next = 1'b0;
            if (mode == MODE_IDLE) begin
              tone_active_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.tone_on = tone_active_next;
  assign res.tone_freq = tone_active_next ? tone_value_next : '0;
  assign res.player_mode = mode_code(mode_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pattern_step <= '0;
      phase_elapsed <= '0;
      sweep_current <= '0;
      sweep_target <= '0;
      sweep_increment <= '0;
      sweep_interval <= '0;
      indicator_level <= '0;
      indicator_beeping <= 1'b0;
      tone_active <= 1'b0;
      tone_value <= '0;
    end else begin
      mode <= mode_next;
      pattern_step <= pattern_step_next;
      phase_elapsed <= phase_elapsed_next;
      sweep_current <= sweep_current_next;
      sweep_target <= sweep_target_next;
      sweep_increment <= sweep_increment_next;
      sweep_interval <= sweep_interval_next;
      indicator_level <= indicator_level_next;
      indicator_beeping <= indicator_beeping_next;
      tone_active <= tone_active_next;
      tone_value <= tone_value_next;
    end
  end
endmodule
`default_nettype wire

// ===== sim/buzzer_tone_pattern_sequencer_core_tb.sv =====
// Self-checking testbench for the buzzer tone sequencer core with a built-in behavior predictor.
`timescale 1ns / 1ps
module buzzer_tone_pattern_sequencer_core_tb;
  import bts_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned RANDOM_PER_PHASE = 370;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [LEVEL_W-1:0] lvl_from;
    logic [LEVEL_W-1:0] lvl_to;
  } command_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bts_in_if cmd_ch ();
  bts_out_if tone_ch ();

  buzzer_tone_pattern_sequencer_core uut (
    .clk(clk),
    .rst(rst),
    .item(cmd_ch.sink),
    .result(tone_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  command_t cmd_pending_q[$];
  result_t tone_expect_q[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;

  // Shadow of the sequencer state.
  cfg_t regs;
  logic [MODE_W-1:0] p_mode;
  logic [STEP_W-1:0] p_step;
  logic [PE_W-1:0] p_elapsed;
  logic [FREQ_W-1:0] sw_cur, sw_tgt;
  logic [INC_W-1:0] sw_inc;
  logic [IV_W-1:0] sw_iv;
  logic [CP_W-1:0] cyc_pos;
  logic [LVL_W-1:0] ind_level;
  bit ind_on;
  bit buzz_on;
  logic [FREQ_W-1:0] buzz_freq;

  function automatic void sequencer_clear();
    regs = CFG_RESET;
    p_mode = PM_IDLE;
    p_step = '0;
    p_elapsed = '0;
    sw_cur = '0;
    sw_tgt = '0;
    sw_inc = '0;
    sw_iv = '0;
    cyc_pos = '0;
    ind_level = '0;
    ind_on = 1'b0;
    buzz_on = 1'b0;
    buzz_freq = '0;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_BEEP_FREQ:   regs.beep_frequency = val;
      CFG_BEEP_LENGTH: regs.beep_length_ms = val[7:0];
      CFG_SWEEP_LEN:   regs.sweep_length_ms = val[SLEN_W-1:0];
      CFG_END_HOLD:    regs.end_hold_ms = val[7:0];
      CFG_SLOT_LENGTH: regs.slot_length_ms = val[POS_W-1:0];
      CFG_SLOT_BEEP:   regs.slot_beep_ms = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [FREQ_W-1:0] level_hz(logic [LVL_W-1:0] lvl);
    case (lvl)
      3'd0: return 12'd2000;
      3'd1: return 12'd2400;
      3'd2: return 12'd2700;
      3'd3: return 12'd3000;
      3'd4: return 12'd3200;
      3'd5: return 12'd3400;
      default: return 12'd3600;
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] clamp_level(logic [LEVEL_W-1:0] v);
    return (v > MAX_LEVEL_DEF) ? LVL_W'(MAX_LEVEL_DEF) : v[LVL_W-1:0];
  endfunction

  function automatic void drive_tone(logic [FREQ_W-1:0] hz);
    buzz_on = 1'b1;
    buzz_freq = hz;
  endfunction

  function automatic void start_pattern(logic [MODE_W-1:0] m);
    p_mode = m;
    p_step = '0;
    p_elapsed = '0;
  endfunction

  function automatic void start_sweep(logic [FREQ_W-1:0] f_from, logic [FREQ_W-1:0] f_to,
                                      int unsigned len, bit up);
    logic [FREQ_W-1:0] diff;
    int unsigned inc, iv;
    diff = up ? f_to - f_from : f_from - f_to;
    inc = diff / SWEEP_STEPS_DEF;
    iv = len / SWEEP_STEPS_DEF;
    if (inc < 1) inc = 1;
    if (iv > IV_MAX) iv = IV_MAX;
    sw_cur = f_from;
    sw_tgt = f_to;
    sw_inc = inc[INC_W-1:0];
    sw_iv = iv[IV_W-1:0];
    p_mode = up ? PM_UP : PM_DOWN;
    p_elapsed = '0;
    drive_tone(f_from);
  endfunction

  function automatic void timed_step(int unsigned wait_ms, logic [FREQ_W-1:0] hz, bit silent);
    if (p_elapsed >= wait_ms) begin
      if (silent) buzz_on = 1'b0;
      else drive_tone(hz);
      p_step = p_step + 1'b1;
      p_elapsed = '0;
    end
  endfunction

  function automatic void indicator_ms();
    int unsigned len, slot, pos;
    bit want;
    if (ind_level == 0) return;
    len = (regs.slot_length_ms == 0) ? 1 : regs.slot_length_ms;
    slot = cyc_pos / len;
    if (slot > MAX_LEVEL_DEF - 1) slot = MAX_LEVEL_DEF - 1;
    pos = cyc_pos % len;
    want = (slot < ind_level) && (pos < regs.slot_beep_ms);
    if (p_mode == PM_IDLE) begin
      if (want != ind_on) begin
        if (want) drive_tone(level_hz(ind_level));
        else buzz_on = 1'b0;
        ind_on = want;
      end
    end else begin
      ind_on = 1'b0;
    end
  endfunction

  function automatic void player_ms();
    int nxt;
    case (p_mode)
      PM_BEEP: begin
        if (p_elapsed >= regs.beep_length_ms) begin
          buzz_on = 1'b0;
          p_mode = PM_IDLE;
        end
      end
      PM_UP, PM_DOWN: begin
        if (p_elapsed >= sw_iv) begin
          p_elapsed = '0;
          nxt = (p_mode == PM_UP) ? int'(sw_cur) + int'(sw_inc) : int'(sw_cur) - int'(sw_inc);
          if ((p_mode == PM_UP) ? (nxt >= int'(sw_tgt)) : (nxt <= int'(sw_tgt))) begin
            drive_tone(sw_tgt);
            p_mode = PM_END;
          end else begin
            sw_cur = nxt[FREQ_W-1:0];
            drive_tone(sw_cur);
          end
        end
      end
      PM_TO1: begin
        if (p_step == 0) timed_step(50, F_LOW_BLIP, 1'b0);
        else if (p_step == 1) timed_step(50, F_HIGH_BLIP, 1'b0);
        else if (p_step == 2) timed_step(50, F_LOW_BLIP, 1'b0);
        else if (p_elapsed >= 80) begin
          p_mode = PM_END;
          p_elapsed = '0;
        end
      end
      PM_TO0: begin
        if (p_elapsed >= 10) begin
          p_elapsed = '0;
          if (p_step < TO0_STEPS) begin
            drive_tone(FREQ_W'(int'(F_TO0_START) - 3 * int'(p_step) * int'(p_step)));
            p_step = p_step + 1'b1;
          end else begin
            p_mode = PM_END;
          end
        end
      end
      PM_SLEEP: begin
        if (p_step < 7) timed_step(60, p_step[0] ? F_SLEEP_HIGH : F_SLEEP_LOW, 1'b0);
        else if (p_elapsed >= 60) start_sweep(F_SLEEP_HIGH, F_SLEEP_END, SLEEP_SWEEP_MS, 1'b0);
      end
      PM_WAKE: begin
        if (p_step == 0) timed_step(70, '0, 1'b1);
        else if (p_step == 1) timed_step(25, F_WAKE_MID, 1'b0);
        else if (p_step == 2) timed_step(70, '0, 1'b1);
        else if (p_step == 3) timed_step(25, F_WAKE_HIGH, 1'b0);
        else if (p_elapsed >= 130) begin
          p_mode = PM_END;
          p_elapsed = '0;
        end
      end
      PM_END: begin
        if (p_elapsed >= regs.end_hold_ms) begin
          buzz_on = 1'b0;
          p_mode = PM_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t next_buzzer_drive(command_t c);
    logic [LVL_W-1:0] lf, lt;
    result_t r;
    lf = clamp_level(c.lvl_from);
    lt = clamp_level(c.lvl_to);
    case (c.cmd)
      CMD_TICK: begin
        if (cyc_pos == CP_W'(CYCLE_MS - 1)) cyc_pos = '0;
        else cyc_pos = cyc_pos + 1'b1;
        if (p_elapsed < 1023) p_elapsed = p_elapsed + 1'b1;
        indicator_ms();
        player_ms();
      end
      CMD_BUTTON: begin
        if (p_mode == PM_IDLE || p_mode == PM_BEEP) begin
          p_mode = PM_BEEP;
          p_elapsed = '0;
          drive_tone(regs.beep_frequency);
        end
      end
      CMD_LEVEL: begin
        if (lf != lt) begin
          if (lt == 1) begin
            start_pattern(PM_TO1);
            drive_tone(F_HIGH_BLIP);
          end else if (lt == 0 && lf == 1) begin
            start_pattern(PM_TO0);
            drive_tone(F_TO0_START);
          end else begin
            start_sweep(level_hz(lf), level_hz(lt), regs.sweep_length_ms, lt > lf);
          end
        end
      end
      CMD_SLEEP: begin
        start_pattern(PM_SLEEP);
        drive_tone(F_SLEEP_HIGH);
      end
      CMD_WAKE: begin
        start_pattern(PM_WAKE);
        drive_tone(F_LOW_BLIP);
      end
      CMD_SET_IND: begin
        ind_level = lt;
        if (lt == 0) begin
          ind_on = 1'b0;
          if (p_mode == PM_IDLE) buzz_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.tone_on = buzz_on;
    r.tone_freq = buzz_on ? buzz_freq : '0;
    r.player_mode = p_mode;
    return r;
  endfunction

  function automatic void field_error(string name, int unsigned want_v, int unsigned got_v);
    errors++;
    $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sender: bursts of transfers separated by random gaps.
  int unsigned burst_left, gap_left;
  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_pending_q.size() != 0) begin
        c = cmd_pending_q.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= c.cmd;
        cmd_ch.level_from <= c.lvl_from;
        cmd_ch.level_to <= c.lvl_to;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns, plus long holds on request.
  int unsigned stall_mode, mode_left, hold_left, holds_done;
  always @(posedge clk) begin
    if (rst) begin
      tone_ch.ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      tone_ch.ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
      tone_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: tone_ch.ready <= 1'b1;
        1: tone_ch.ready <= ($urandom_range(0, 3) != 0);
        default: tone_ch.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Monitor: predicts on each command transfer and checks each result transfer.
  always @(posedge clk) begin
    command_t c;
    result_t want, seen;
    if (rst) begin
      sequencer_clear();
    end else begin
      if (cfg_we) store_reg(cfg_index, cfg_data);
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.cmd = cmd_ch.cmd;
        c.lvl_from = cmd_ch.level_from;
        c.lvl_to = cmd_ch.level_to;
        tone_expect_q.push_back(next_buzzer_drive(c));
      end
      if (tone_ch.valid && tone_ch.ready) begin
        seen.tone_on = tone_ch.tone_on;
        seen.tone_freq = tone_ch.tone_freq;
        seen.player_mode = tone_ch.player_mode;
        if (tone_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, expected none, actual %h", $time, seen);
        end else begin
          want = tone_expect_q.pop_front();
          if (seen.tone_on !== want.tone_on)
            field_error("tone_on", want.tone_on, seen.tone_on);
          if (seen.tone_freq !== want.tone_freq)
            field_error("tone_freq", want.tone_freq, seen.tone_freq);
          if (seen.player_mode !== want.player_mode)
            field_error("player_mode", want.player_mode, seen.player_mode);
        end
      end
    end
  end

  task automatic push_item(logic [CMD_W-1:0] c, logic [LEVEL_W-1:0] f, logic [LEVEL_W-1:0] t);
    command_t it;
    it.cmd = c;
    it.lvl_from = f;
    it.lvl_to = t;
    cmd_pending_q.push_back(it);
  endtask

  function automatic logic [LEVEL_W-1:0] random_level();
    if ($urandom_range(0, 3) != 0) return LEVEL_W'($urandom_range(0, 7));
    return LEVEL_W'($urandom());
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (cmd_pending_q.size() != 0 || cmd_ch.valid || tone_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random(int unsigned count);
    int unsigned added, run, pick;
    logic [CMD_W-1:0] c;
    logic [LEVEL_W-1:0] f, t;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      f = random_level();
      t = random_level();
      if (pick < 20) c = CMD_BUTTON;
      else if (pick < 50) begin
        c = CMD_LEVEL;
        case ($urandom_range(0, 3))
          0: begin
            f = 8'd1;
            t = 8'd0;
          end
          1: t = 8'd1;
          default: ;
        endcase
      end
      else if (pick < 58) c = CMD_SLEEP;
      else if (pick < 68) c = CMD_WAKE;
      else if (pick < 92) c = CMD_SET_IND;
      else c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      push_item(c, f, t);
      added++;
      pick = $urandom_range(0, 9);
      if (pick < 6) run = $urandom_range(0, 25);
      else if (pick < 9) run = $urandom_range(0, 350);
      else run = $urandom_range(300, 1100);
      if (run > count - added) run = count - added;
      repeat (run) begin
        if ($urandom_range(0, 59) == 0) push_item(CMD_BUTTON, random_level(), random_level());
        else push_item(CMD_TICK, LEVEL_W'($urandom()), LEVEL_W'($urandom()));
        added++;
      end
    end
  endtask

  task automatic program_setting(int unsigned setting);
    int unsigned bf, bl, sl, eh, sn, sb;
    case (setting)
      1: begin
        bf = 0; bl = 0; sl = 0; eh = 0; sn = 0; sb = 0;
      end
      2: begin
        bf = 4095; bl = 255; sl = 1023; eh = 255; sn = 255; sb = 255;
      end
      default: begin
        bf = $urandom_range(0, 4095);
        bl = $urandom_range(0, 60);
        sl = $urandom_range(0, 220);
        eh = $urandom_range(0, 40);
        sn = $urandom_range(0, 40);
        sb = $urandom_range(0, 40);
      end
    endcase
    write_reg(CFG_BEEP_FREQ, bf);
    write_reg(CFG_BEEP_LENGTH, bl);
    write_reg(CFG_SWEEP_LEN, sl);
    write_reg(CFG_END_HOLD, eh);
    write_reg(CFG_SLOT_BEEP, sb);
    write_reg(CFG_SLOT_LENGTH, sn);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_TICK;
    cmd_ch.level_from = '0;
    cmd_ch.level_to = '0;
    tone_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_item(CMD_TICK, 8'hFF, 8'hFF);
    push_item(CMD_SET_IND, 8'd0, 8'd3);
    push_item(CMD_TICK, 8'd0, 8'd0);
    push_item(CMD_BUTTON, 8'd0, 8'd0);
    push_item(CMD_BUTTON, 8'd0, 8'd0);
    push_item(CMD_SPARE_LO, 8'd0, 8'd0);
    push_item(CMD_SPARE_HI, 8'hFF, 8'hFF);
    push_item(CMD_TICK, 8'd0, 8'd0);
    push_item(CMD_LEVEL, 8'd3, 8'd3);
    push_item(CMD_LEVEL, 8'd200, 8'd7);
    push_item(CMD_LEVEL, 8'd0, 8'd1);
    push_item(CMD_BUTTON, 8'd0, 8'd0);
    push_item(CMD_SET_IND, 8'd0, 8'd0);
    push_item(CMD_LEVEL, 8'd1, 8'd0);
    push_item(CMD_TICK, 8'd0, 8'd0);
    push_item(CMD_LEVEL, 8'd255, 8'd0);
    push_item(CMD_TICK, 8'd0, 8'd0);
    push_item(CMD_LEVEL, 8'd0, 8'd255);
    push_item(CMD_LEVEL, 8'd2, 8'd0);
    push_item(CMD_SLEEP, 8'd0, 8'd0);
    push_item(CMD_TICK, 8'd0, 8'd0);
    push_item(CMD_WAKE, 8'd0, 8'd0);
    push_item(CMD_SET_IND, 8'd0, 8'd255);
    push_item(CMD_TICK, 8'd0, 8'd0);
    add_random(RANDOM_PER_PHASE);
    drain();

    for (int unsigned setting = 1; setting < 5; setting++) begin
      program_setting(setting);
      if (setting % 2 == 0) hold_requests++;
      add_random(RANDOM_PER_PHASE);
      drain();
    end

    repeat (12) @(posedge clk);
    if (errors == 0 && tone_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/bts_pkg.sv
src/bts_in_if.sv
src/bts_out_if.sv
src/bts_slot_track.sv
src/bts_player.sv
src/buzzer_tone_pattern_sequencer_core.sv
sim/buzzer_tone_pattern_sequencer_core_tb.sv
